// File: sv/icmp_rm_pkg.sv
// Shared types and constants for the ICMP reply matcher.
// No dependencies; every other file in sv/ but icmp_rm_in_if.sv uses this package.
`default_nettype none

package icmp_rm_pkg;

    // Default receive buffer size in bytes; the byte counter saturates here
    localparam int MAX_PACKET_BYTES_DEF = 4096;

    // Configuration register indexes
    localparam int CFG_INDEX_W = 1;
    localparam logic [CFG_INDEX_W-1:0] REG_EXPECTED_IDENT    = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_EXPECTED_SEQUENCE = 1'b1;

    localparam logic [15:0] EXPECTED_IDENT_RST    = 16'd1;
    localparam logic [15:0] EXPECTED_SEQUENCE_RST = 16'd215;

    // IPv4 header fields
    localparam logic [7:0] IP_VERSION_MASK   = 8'hf0;
    localparam logic [7:0] IP_VERSION_4      = 8'h40;
    localparam logic [7:0] IP_IHL_MASK       = 8'h0f;
    localparam logic [7:0] IP_PROTO_ICMP     = 8'd1;
    localparam int         IP_PROTO_OFFSET   = 9;
    localparam int         IP_SRC_FIRST      = 12;
    localparam int         IP_SRC_LAST       = 15;
    localparam logic [3:0] IP_IHL_MIN        = 4'd5;
    localparam logic [5:0] IP_MIN_HDR_BYTES  = 6'd20;

    // ICMP fields, offsets relative to the end of the IP header
    localparam logic [7:0] ICMP_ECHO_REPLY    = 8'd0;
    localparam logic [7:0] ICMP_TIME_EXCEEDED = 8'd11;
    localparam int         ICMP_IDENT_HI      = 4;
    localparam int         ICMP_IDENT_LO      = 5;
    localparam int         ICMP_SEQ_HI        = 6;
    localparam int         ICMP_SEQ_LO        = 7;
    localparam int         ICMP_ECHO_BYTES    = 8;

    localparam int MIN_PACKET_BYTES = 36;

    typedef enum logic [1:0] {
        REPLY_NONE          = 2'd0,
        REPLY_ECHO_MATCH    = 2'd1,
        REPLY_TIME_EXCEEDED = 2'd2
    } reply_kind_t;

    // Header and ICMP fields collected while a datagram streams in
    typedef struct packed {
        logic        header_valid;
        logic [5:0]  header_bytes;
        logic [31:0] source_address;
        logic [7:0]  message_type;
        logic [15:0] seen_ident;
        logic [15:0] seen_sequence;
    } pkt_fields_t;

    localparam pkt_fields_t PKT_FIELDS_RST = '{
        header_valid:   1'b0,
        header_bytes:   IP_MIN_HDR_BYTES,
        source_address: 32'd0,
        message_type:   8'd0,
        seen_ident:     16'd0,
        seen_sequence:  16'd0
    };

endpackage

`default_nettype wire

// File: sv/icmp_rm_in_if.sv
// Byte stream channel carrying received datagram bytes.
// Depends on icmp_rm_pkg only by convention; carries plain fields.
`default_nettype none

interface icmp_rm_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

`default_nettype wire

// File: sv/icmp_rm_out_if.sv
// Result channel: one beat per datagram with the match kind and source address.
// Depends on icmp_rm_pkg for reply_kind_t.
`default_nettype none

interface icmp_rm_out_if;
    logic                     valid;
    logic                     ready;
    icmp_rm_pkg::reply_kind_t reply_kind;
    logic [31:0]              responder_ip;

    modport source (output valid, output reply_kind, output responder_ip, input ready);
    modport sink   (input valid, input reply_kind, input responder_ip, output ready);
endinterface

`default_nettype wire

// File: sv/icmp_rm_cfg_if.sv
// Configuration write channel: register index and write data.
// Depends on icmp_rm_pkg for the index width.
`default_nettype none

interface icmp_rm_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [icmp_rm_pkg::CFG_INDEX_W-1:0] index;
    logic [15:0]                        data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: sv/icmp_reply_matcher.sv
// ICMP reply matcher: classifies received IPv4 datagrams streamed one byte a beat.
// Depends on icmp_rm_pkg, the three channel interfaces and the icmp_rm_* modules.
//
// Usage:
//   pkt_in carries one datagram byte per beat, header first; last_byte marks
//   the final byte. result_out gives one beat per datagram: reply_kind 1 for
//   an echo reply whose identifier and sequence equal the configured values,
//   2 for a valid time-exceeded message, 0 otherwise; responder_ip holds the IPv4
//   source address for kind 1 or 2 and 0 otherwise. cfg writes register 0
//   (expected identifier, reset 1) or register 1 (expected sequence, reset
//   215); it is always ready and should be written while no datagram is open.
//   A byte is taken every cycle unless the output stalls. The result beat
//   appears in the cycle after the last byte is accepted, from a single
//   output register. While result_out is stalled, pkt_in stays ready only
//   if that register is being emptied in the same cycle, so the input
//   stalls with the output. Bytes beyond MAX_PACKET_BYTES are dropped and
//   the length saturates there. Reset clears the byte counter and captured
//   fields, restores the configuration registers and empties the output register.
`default_nettype none

module icmp_reply_matcher #(
    parameter int MAX_PACKET_BYTES = icmp_rm_pkg::MAX_PACKET_BYTES_DEF
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    icmp_rm_in_if.sink      pkt_in,
    icmp_rm_out_if.source   result_out,
    icmp_rm_cfg_if.sink     cfg
);
    import icmp_rm_pkg::*;

    localparam int OFF_W = $clog2(MAX_PACKET_BYTES + 1);

    pkt_fields_t       fields;
    logic [OFF_W-1:0]  length;
    logic              done;
    logic              can_take;
    logic [15:0]       expected_ident;
    logic [15:0]       expected_sequence;

    icmp_rm_cfg_regs u_cfg_regs (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg               (cfg),
        .expected_ident    (expected_ident),
        .expected_sequence (expected_sequence)
    );

    icmp_rm_parser #(
        .MAX_PACKET_BYTES (MAX_PACKET_BYTES),
        .OFF_W            (OFF_W)
    ) u_parser (
        .clk      (clk),
        .rst_n    (rst_n),
        .pkt_in   (pkt_in),
        .can_take (can_take),
        .fields   (fields),
        .length   (length),
        .done     (done)
    );

    icmp_rm_result #(
        .OFF_W (OFF_W)
    ) u_result (
        .clk               (clk),
        .rst_n             (rst_n),
        .fields            (fields),
        .length            (length),
        .done              (done),
        .expected_ident    (expected_ident),
        .expected_sequence (expected_sequence),
        .can_take          (can_take),
        .result_out        (result_out)
    );

endmodule

`default_nettype wire

// File: sv/icmp_rm_cfg_regs.sv
// Configuration registers: expected echo identifier and sequence number.
// Depends on icmp_rm_pkg and icmp_rm_cfg_if.
`default_nettype none

module icmp_rm_cfg_regs (
    input  wire logic        clk,
    input  wire logic        rst_n,
    icmp_rm_cfg_if.sink      cfg,
    output logic [15:0]      expected_ident,
    output logic [15:0]      expected_sequence
);
    import icmp_rm_pkg::*;

    logic [15:0] ident_reg;
    logic [15:0] ident_next;
    logic [15:0] sequence_reg;
    logic [15:0] sequence_next;
    logic        wr_en;

    assign cfg.ready = 1'b1;
    assign wr_en     = cfg.valid && cfg.ready;

    always_comb
    begin
        ident_next    = ident_reg;
        sequence_next = sequence_reg;
        if (wr_en)
        begin
            unique case (cfg.index)
                REG_EXPECTED_IDENT:    ident_next    = cfg.data;
                REG_EXPECTED_SEQUENCE: sequence_next = cfg.data;
                default:               ident_next    = ident_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ident_reg    <= EXPECTED_IDENT_RST;
            sequence_reg <= EXPECTED_SEQUENCE_RST;
        end
        else
        begin
            ident_reg    <= ident_next;
            sequence_reg <= sequence_next;
        end
    end

    assign expected_ident    = ident_reg;
    assign expected_sequence = sequence_reg;

endmodule

`default_nettype wire

// File: sv/icmp_rm_parser.sv
// Per-byte field capture: offset counter, IPv4 header checks, ICMP fields.
// Depends on icmp_rm_pkg and icmp_rm_in_if.
`default_nettype none

module icmp_rm_parser #(
    parameter int MAX_PACKET_BYTES = icmp_rm_pkg::MAX_PACKET_BYTES_DEF,
    parameter int OFF_W            = $clog2(MAX_PACKET_BYTES + 1)
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    icmp_rm_in_if.sink                     pkt_in,
    input  wire logic                      can_take,
    output icmp_rm_pkg::pkt_fields_t       fields,
    output logic [OFF_W-1:0]               length,
    output logic                           done
);
    import icmp_rm_pkg::*;

    localparam logic [OFF_W-1:0] MAX_OFF = OFF_W'(MAX_PACKET_BYTES);

    pkt_fields_t       fields_reg;
    pkt_fields_t       fields_next;
    pkt_fields_t       fields_taken;
    logic [OFF_W-1:0]  offset_reg;
    logic [OFF_W-1:0]  offset_next;
    logic [OFF_W-1:0]  offset_taken;
    logic [OFF_W-1:0]  hdr_ext;
    logic [3:0]        ihl;
    logic [7:0]        b;
    logic              accept;

    assign pkt_in.ready = can_take;
    assign accept       = pkt_in.valid && pkt_in.ready;
    assign b            = pkt_in.data_byte;
    assign ihl          = b[3:0];
    assign hdr_ext      = OFF_W'(fields_reg.header_bytes);

    // Fold the accepted byte into the collected fields
    always_comb
    begin
        fields_taken = fields_reg;
        offset_taken = offset_reg;
        if (accept && (offset_reg < MAX_OFF))
        begin
            offset_taken = offset_reg + OFF_W'(1);
            if (offset_reg == '0)
            begin
                fields_taken.header_valid = ((b & IP_VERSION_MASK) == IP_VERSION_4);
                fields_taken.header_bytes = (ihl <= IP_IHL_MIN) ? IP_MIN_HDR_BYTES
                                                                : {ihl, 2'b00};
            end
            if ((offset_reg == OFF_W'(IP_PROTO_OFFSET)) && (b != IP_PROTO_ICMP))
                fields_taken.header_valid = 1'b0;
            if ((offset_reg >= OFF_W'(IP_SRC_FIRST)) && (offset_reg <= OFF_W'(IP_SRC_LAST)))
                fields_taken.source_address = {fields_reg.source_address[23:0], b};
            if (offset_reg == hdr_ext)
                fields_taken.message_type = b;
            if ((offset_reg == hdr_ext + OFF_W'(ICMP_IDENT_HI)) ||
                (offset_reg == hdr_ext + OFF_W'(ICMP_IDENT_LO)))
                fields_taken.seen_ident = {fields_reg.seen_ident[7:0], b};
            if ((offset_reg == hdr_ext + OFF_W'(ICMP_SEQ_HI)) ||
                (offset_reg == hdr_ext + OFF_W'(ICMP_SEQ_LO)))
                fields_taken.seen_sequence = {fields_reg.seen_sequence[7:0], b};
        end
    end

    // Start over after the last byte of a datagram
    always_comb
    begin
        if (done)
        begin
            fields_next = PKT_FIELDS_RST;
            offset_next = '0;
        end
        else
        begin
            fields_next = fields_taken;
            offset_next = offset_taken;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fields_reg <= PKT_FIELDS_RST;
            offset_reg <= '0;
        end
        else
        begin
            fields_reg <= fields_next;
            offset_reg <= offset_next;
        end
    end

    assign done   = accept && pkt_in.last_byte;
    assign fields = fields_taken;
    assign length = offset_taken;

endmodule

`default_nettype wire

// File: sv/icmp_rm_result.sv
// Datagram classification and the output register that holds the result beat.
// Depends on icmp_rm_pkg and icmp_rm_out_if.
`default_nettype none

module icmp_rm_result #(
    parameter int OFF_W = $clog2(icmp_rm_pkg::MAX_PACKET_BYTES_DEF + 1)
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire icmp_rm_pkg::pkt_fields_t   fields,
    input  wire logic [OFF_W-1:0]           length,
    input  wire logic                       done,
    input  wire logic [15:0]                expected_ident,
    input  wire logic [15:0]                expected_sequence,
    output logic                            can_take,
    icmp_rm_out_if.source                   result_out
);
    import icmp_rm_pkg::*;

    reply_kind_t  kind;
    reply_kind_t  kind_reg;
    reply_kind_t  kind_next;
    logic [31:0]  ip_reg;
    logic [31:0]  ip_next;
    logic         valid_reg;
    logic         valid_next;
    logic [OFF_W-1:0] hdr_ext;
    logic         frame_ok;

    assign hdr_ext  = OFF_W'(fields.header_bytes);
    assign frame_ok = (length >= OFF_W'(MIN_PACKET_BYTES)) && fields.header_valid &&
                      (length > hdr_ext);

    always_comb
    begin
        kind = REPLY_NONE;
        if (frame_ok)
        begin
            priority if (fields.message_type == ICMP_ECHO_REPLY)
            begin
                if ((length >= hdr_ext + OFF_W'(ICMP_ECHO_BYTES)) &&
                    (fields.seen_ident == expected_ident) &&
                    (fields.seen_sequence == expected_sequence))
                    kind = REPLY_ECHO_MATCH;
            end
            else if (fields.message_type == ICMP_TIME_EXCEEDED)
                kind = REPLY_TIME_EXCEEDED;
            else
                kind = REPLY_NONE;
        end
    end

    // Load on the last byte, hold while the receiver stalls, drop once taken
    always_comb
    begin
        kind_next  = kind_reg;
        ip_next    = ip_reg;
        valid_next = valid_reg && !result_out.ready;
        if (done)
        begin
            kind_next  = kind;
            ip_next    = (kind != REPLY_NONE) ? fields.source_address : 32'd0;
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        kind_reg <= kind_next;
        ip_reg   <= ip_next;
    end

    assign can_take                = !valid_reg || result_out.ready;
    assign result_out.valid        = valid_reg;
    assign result_out.reply_kind   = kind_reg;
    assign result_out.responder_ip = ip_reg;

endmodule

`default_nettype wire

// File: bench/testbench.sv
// Self-checking bench for icmp_reply_matcher: directed datagrams, then random ones per configuration.
// Depends on icmp_rm_pkg, the three channel interfaces and the icmp_reply_matcher RTL.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import icmp_rm_pkg::*;

    localparam logic [7:0] ICMP_DEST_UNREACH = 8'd3;
    localparam logic [7:0] ICMP_ECHO_REQUEST = 8'd8;
    localparam logic [7:0] IP_PROTO_TCP      = 8'd6;
    localparam int CYCLE_LIMIT   = 3000000;
    localparam int DRAIN_CYCLES  = 8;
    localparam int PHASES        = 6;
    localparam int PHASE_BYTES   = 140;
    localparam int PHASE_FRAMES  = 7;
    localparam int PRINT_CAP     = 50;

    typedef struct packed {
        reply_kind_t kind;
        logic [31:0] ip;
    } verdict_t;

    typedef struct packed {
        logic [7:0]  ver_ihl;
        logic [7:0]  proto;
        logic [31:0] src;
        logic [7:0]  msg_type;
        logic [15:0] ident;
        logic [15:0] seq;
        logic [15:0] len;
        logic        typed;
        reply_kind_t kind;
        logic [31:0] want_ip;
        logic        raw;
    } probe_row_t;

    localparam probe_row_t PROBES [20] = '{
        '{8'h45, IP_PROTO_ICMP, 32'hc0a80101, ICMP_ECHO_REPLY, EXPECTED_IDENT_RST,
          EXPECTED_SEQUENCE_RST, 16'd36, 1'b1, REPLY_ECHO_MATCH, 32'hc0a80101, 1'b0},
        '{8'h45, IP_PROTO_ICMP, 32'hffffffff, ICMP_TIME_EXCEEDED, 16'h0000, 16'h0000,
          16'd36, 1'b1, REPLY_TIME_EXCEEDED, 32'hffffffff, 1'b0},
        '{8'h45, IP_PROTO_ICMP, 32'h00000000, ICMP_ECHO_REPLY, EXPECTED_IDENT_RST,
          EXPECTED_SEQUENCE_RST, 16'd36, 1'b1, REPLY_ECHO_MATCH, 32'h0, 1'b0},
        '{8'h45, IP_PROTO_ICMP, 32'h0a000001, ICMP_ECHO_REQUEST, EXPECTED_IDENT_RST,
          EXPECTED_SEQUENCE_RST, 16'd64, 1'b1, REPLY_NONE, 32'h0, 1'b0},
        '{8'h45, IP_PROTO_ICMP, 32'h0a000002, ICMP_DEST_UNREACH, 16'h0, 16'h0,
          16'd56, 1'b1, REPLY_NONE, 32'h0, 1'b0},
        // wrong version
        '{8'h65, IP_PROTO_ICMP, 32'h0a000003, ICMP_TIME_EXCEEDED, 16'h0, 16'h0,
          16'd48, 1'b1, REPLY_NONE, 32'h0, 1'b0},
        '{8'h45, IP_PROTO_TCP, 32'h0a000004, ICMP_TIME_EXCEEDED, 16'h0, 16'h0,
          16'd48, 1'b1, REPLY_NONE, 32'h0, 1'b0},
        // one byte short of the minimum datagram
        '{8'h45, IP_PROTO_ICMP, 32'h0a000005, ICMP_TIME_EXCEEDED, 16'h0, 16'h0,
          16'd35, 1'b1, REPLY_NONE, 32'h0, 1'b0},
        '{8'h45, IP_PROTO_ICMP, 32'h0a000006, ICMP_ECHO_REPLY, EXPECTED_IDENT_RST + 16'd1,
          EXPECTED_SEQUENCE_RST, 16'd40, 1'b1, REPLY_NONE, 32'h0, 1'b0},
        '{8'h45, IP_PROTO_ICMP, 32'h0a000007, ICMP_ECHO_REPLY, EXPECTED_IDENT_RST,
          EXPECTED_SEQUENCE_RST + 16'd1, 16'd40, 1'b1, REPLY_NONE, 32'h0, 1'b0},
        // IHL below the minimum counts as a 20 byte header
        '{8'h40, IP_PROTO_ICMP, 32'h0a000008, ICMP_TIME_EXCEEDED, 16'h0, 16'h0,
          16'd36, 1'b1, REPLY_TIME_EXCEEDED, 32'h0a000008, 1'b0},
        '{8'h4f, IP_PROTO_ICMP, 32'h7f000001, ICMP_ECHO_REPLY, EXPECTED_IDENT_RST,
          EXPECTED_SEQUENCE_RST, 16'd68, 1'b0, REPLY_NONE, 32'h0, 1'b0},
        // datagram ends right before the ICMP type byte
        '{8'h4f, IP_PROTO_ICMP, 32'h7f000002, ICMP_TIME_EXCEEDED, 16'h0, 16'h0,
          16'd60, 1'b1, REPLY_NONE, 32'h0, 1'b0},
        '{8'h4f, IP_PROTO_ICMP, 32'h7f000003, ICMP_TIME_EXCEEDED, 16'h0, 16'h0,
          16'd61, 1'b0, REPLY_NONE, 32'h0, 1'b0},
        // echo reply with only seven ICMP bytes
        '{8'h4a, IP_PROTO_ICMP, 32'h7f000004, ICMP_ECHO_REPLY, EXPECTED_IDENT_RST,
          EXPECTED_SEQUENCE_RST, 16'd47, 1'b1, REPLY_NONE, 32'h0, 1'b0},
        '{8'h4a, IP_PROTO_ICMP, 32'h7f000005, ICMP_ECHO_REPLY, EXPECTED_IDENT_RST,
          EXPECTED_SEQUENCE_RST, 16'd48, 1'b0, REPLY_NONE, 32'h0, 1'b0},
        '{8'h46, IP_PROTO_ICMP, 32'h7f000006, ICMP_ECHO_REPLY, EXPECTED_IDENT_RST,
          EXPECTED_SEQUENCE_RST, 16'd36, 1'b0, REPLY_NONE, 32'h0, 1'b0},
        // overlong datagram: the byte counter saturates
        '{8'h45, IP_PROTO_ICMP, 32'h5a5aa5a5, ICMP_TIME_EXCEEDED, 16'h0, 16'h0,
          16'd4100, 1'b0, REPLY_NONE, 32'h0, 1'b0},
        '{8'h45, IP_PROTO_ICMP, 32'h0, ICMP_TIME_EXCEEDED, 16'h0, 16'h0,
          16'd1, 1'b1, REPLY_NONE, 32'h0, 1'b0},
        '{8'hff, 8'hff, 32'hffffffff, 8'hff, 16'hffff, 16'hffff,
          16'd40, 1'b1, REPLY_NONE, 32'h0, 1'b0}
    };

    logic clk;
    logic rst_n;

    icmp_rm_in_if  pkt_bus ();
    icmp_rm_out_if res_bus ();
    icmp_rm_cfg_if cfg_bus ();

    icmp_reply_matcher i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .pkt_in     (pkt_bus),
        .result_out (res_bus),
        .cfg        (cfg_bus)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // Predictor state: configuration and fields captured from the open datagram
    logic [15:0] cfg_ident;
    logic [15:0] cfg_seq;
    logic [12:0] rx_count;
    logic [5:0]  rx_hdr_len;
    logic        rx_hdr_ok;
    logic [31:0] rx_src;
    logic [7:0]  rx_type;
    logic [15:0] rx_ident;
    logic [15:0] rx_seq;

    verdict_t expected_replies [$];
    // One entry per datagram in send order; a set flag overrides the predictor
    bit       typed_flags [$];
    verdict_t typed_list [$];
    verdict_t typed_verdict;
    verdict_t mon_verdict;
    bit       mon_produced;
    int       mismatches;
    int       cycles;
    int       bytes_sent;
    int       frames_sent;
    bit       calm;
    int       out_hold;

    function automatic logic [5:0] hdr_len_of(input logic [7:0] first);
        logic [7:0] ihl;
        ihl = first & IP_IHL_MASK;
        if (ihl[3:0] <= IP_IHL_MIN)
            return IP_MIN_HDR_BYTES;
        return {ihl[3:0], 2'b00};
    endfunction

    function automatic void clear_capture();
        rx_count   = '0;
        rx_hdr_len = IP_MIN_HDR_BYTES;
        rx_hdr_ok  = 1'b0;
        rx_src     = '0;
        rx_type    = '0;
        rx_ident   = '0;
        rx_seq     = '0;
    endfunction

    task automatic classify_byte(input logic [7:0] b, input logic last,
                                 output bit produced, output verdict_t v);
        int at;
        int hl;
        int n;
        produced = 1'b0;
        v.kind   = REPLY_NONE;
        v.ip     = '0;
        if (rx_count < MAX_PACKET_BYTES_DEF)
        begin
            at = int'(rx_count);
            if (at == 0)
            begin
                rx_hdr_ok  = (b & IP_VERSION_MASK) == IP_VERSION_4;
                rx_hdr_len = hdr_len_of(b);
            end
            if (at == IP_PROTO_OFFSET && b != IP_PROTO_ICMP)
                rx_hdr_ok = 1'b0;
            if (at >= IP_SRC_FIRST && at <= IP_SRC_LAST)
                rx_src = {rx_src[23:0], b};
            hl = int'(rx_hdr_len);
            if (at == hl)
                rx_type = b;
            if (at == hl + ICMP_IDENT_HI || at == hl + ICMP_IDENT_LO)
                rx_ident = {rx_ident[7:0], b};
            if (at == hl + ICMP_SEQ_HI || at == hl + ICMP_SEQ_LO)
                rx_seq = {rx_seq[7:0], b};
            rx_count = rx_count + 13'd1;
        end
        if (last)
        begin
            n  = int'(rx_count);
            hl = int'(rx_hdr_len);
            if (n >= MIN_PACKET_BYTES && rx_hdr_ok && n > hl)
            begin
                if (rx_type == ICMP_ECHO_REPLY)
                begin
                    if (n >= hl + ICMP_ECHO_BYTES && rx_ident == cfg_ident && rx_seq == cfg_seq)
                        v.kind = REPLY_ECHO_MATCH;
                end
                else if (rx_type == ICMP_TIME_EXCEEDED)
                    v.kind = REPLY_TIME_EXCEEDED;
            end
            if (v.kind != REPLY_NONE)
                v.ip = rx_src;
            produced = 1'b1;
            clear_capture();
        end
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (mismatches < PRINT_CAP)
            $display("ERROR cycle %0d: %s: got %0h, want %0h", cycles, what, got, want);
        mismatches++;
    endtask

    // Mostly no gap, some short ones, a few long; none at all during calm stretches
    function automatic int pick_gap();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    always @(posedge clk)
    begin
        cycles++;
        if (cycles % 300 == 0)
            calm = ($urandom_range(0, 3) == 0);
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("icmp_reply_matcher test failed");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (pkt_bus.valid && pkt_bus.ready)
            begin
                classify_byte(pkt_bus.data_byte, pkt_bus.last_byte, mon_produced, mon_verdict);
                if (mon_produced)
                begin
                    if (typed_flags.size() != 0)
                    begin
                        typed_verdict = typed_list.pop_front();
                        if (typed_flags.pop_front())
                            mon_verdict = typed_verdict;
                    end
                    expected_replies.push_back(mon_verdict);
                end
            end
            if (res_bus.valid && res_bus.ready)
            begin
                if (expected_replies.size() == 0)
                    report_mismatch("result with nothing pending", res_bus.responder_ip, '0);
                else
                begin
                    mon_verdict = expected_replies.pop_front();
                    if (res_bus.reply_kind != mon_verdict.kind)
                        report_mismatch("reply_kind", 32'(res_bus.reply_kind),
                                        32'(mon_verdict.kind));
                    if (res_bus.responder_ip != mon_verdict.ip)
                        report_mismatch("responder_ip", res_bus.responder_ip, mon_verdict.ip);
                end
            end
            if (cfg_bus.valid && cfg_bus.ready)
            begin
                if (cfg_bus.index == REG_EXPECTED_IDENT)
                    cfg_ident = cfg_bus.data;
                else if (cfg_bus.index == REG_EXPECTED_SEQUENCE)
                    cfg_seq = cfg_bus.data;
            end
        end
    end

    // Result sink: hold ready high, then stall for a random stretch
    initial
    begin
        res_bus.ready = 1'b0;
        out_hold = 0;
        forever
        begin
            @(negedge clk);
            if (out_hold > 0)
            begin
                res_bus.ready <= 1'b0;
                out_hold--;
            end
            else
            begin
                res_bus.ready <= 1'b1;
                out_hold = pick_gap();
            end
        end
    end

    task automatic send_beat(input logic [7:0] b, input logic last);
        int gap;
        gap = pick_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            pkt_bus.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        pkt_bus.valid     <= 1'b1;
        pkt_bus.data_byte <= b;
        pkt_bus.last_byte <= last;
        @(posedge clk);
        while (!pkt_bus.ready)
            @(posedge clk);
        bytes_sent++;
    endtask

    task automatic send_frame(input probe_row_t r);
        int hl;
        int i;
        logic [7:0] b;
        verdict_t tv;
        hl = int'(hdr_len_of(r.ver_ihl));
        tv.kind = r.kind;
        tv.ip   = r.want_ip;
        typed_flags.push_back(r.typed);
        typed_list.push_back(tv);
        for (i = 0; i < r.len; i++)
        begin
            b = 8'($urandom_range(0, 255));
            if (!r.raw)
            begin
                if (i == 0)
                    b = r.ver_ihl;
                else if (i == IP_PROTO_OFFSET)
                    b = r.proto;
                else if (i >= IP_SRC_FIRST && i <= IP_SRC_LAST)
                    b = r.src[8 * (IP_SRC_LAST - i) +: 8];
                else if (i == hl)
                    b = r.msg_type;
                else if (i == hl + ICMP_IDENT_HI)
                    b = r.ident[15:8];
                else if (i == hl + ICMP_IDENT_LO)
                    b = r.ident[7:0];
                else if (i == hl + ICMP_SEQ_HI)
                    b = r.seq[15:8];
                else if (i == hl + ICMP_SEQ_LO)
                    b = r.seq[7:0];
            end
            send_beat(b, i == r.len - 1);
        end
        frames_sent++;
    endtask

    // Mostly well-formed ICMP datagrams with random content, some broken, some noise
    task automatic random_frame();
        probe_row_t r;
        int s;
        int t;
        int hl;
        r = '0;
        r.src = $urandom();
        s = $urandom_range(0, 19);
        r.ver_ihl = {4'h4, ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15)) : 4'd5};
        r.proto   = IP_PROTO_ICMP;
        if (s == 15 || s == 16)
            r.ver_ihl = 8'($urandom_range(0, 255));
        else if (s == 17)
            r.proto = 8'($urandom_range(0, 255));
        else if (s >= 18)
            r.raw = 1'b1;
        t = $urandom_range(0, 9);
        if (t < 5)
            r.msg_type = ICMP_ECHO_REPLY;
        else if (t < 8)
            r.msg_type = ICMP_TIME_EXCEEDED;
        else if (t == 8)
            r.msg_type = ICMP_ECHO_REQUEST;
        else
            r.msg_type = 8'($urandom_range(0, 255));
        r.ident = ($urandom_range(0, 3) != 0) ? cfg_ident : 16'($urandom());
        r.seq   = ($urandom_range(0, 3) != 0) ? cfg_seq : 16'($urandom());
        if ($urandom_range(0, 7) == 0)
            r.seq = cfg_seq ^ (16'd1 << $urandom_range(0, 15));
        hl = int'(hdr_len_of(r.ver_ihl));
        if (r.raw)
            r.len = 16'($urandom_range(1, 40));
        else if ($urandom_range(0, 5) == 0)
            r.len = 16'($urandom_range(1, hl + 10));
        else
            r.len = 16'(hl + ICMP_ECHO_BYTES + int'($urandom_range(0, 16)));
        send_frame(r);
    endtask

    task automatic cfg_write(input logic [CFG_INDEX_W-1:0] idx, input logic [15:0] val);
        @(negedge clk);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= val;
        @(posedge clk);
        while (!cfg_bus.ready)
            @(posedge clk);
        @(negedge clk);
        cfg_bus.valid <= 1'b0;
    endtask

    // Drop valid and let every pending result drain
    task automatic settle();
        @(negedge clk);
        pkt_bus.valid <= 1'b0;
        while (expected_replies.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        int p;
        int i;
        int start_bytes;
        int start_frames;
        logic [15:0] id_val;
        logic [15:0] seq_val;
        rst_n             = 1'b0;
        pkt_bus.valid     = 1'b0;
        pkt_bus.data_byte = '0;
        pkt_bus.last_byte = 1'b0;
        cfg_bus.valid     = 1'b0;
        cfg_bus.index     = REG_EXPECTED_IDENT;
        cfg_bus.data      = '0;
        cfg_ident         = EXPECTED_IDENT_RST;
        cfg_seq           = EXPECTED_SEQUENCE_RST;
        mismatches        = 0;
        cycles            = 0;
        bytes_sent        = 0;
        frames_sent       = 0;
        calm              = 1'b0;
        clear_capture();
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (i = 0; i < $size(PROBES); i++)
            send_frame(PROBES[i]);
        settle();

        for (p = 0; p < PHASES; p++)
        begin
            if (p == 0)
            begin
                id_val  = 16'h0000;
                seq_val = 16'h0000;
            end
            else if (p == 1)
            begin
                id_val  = 16'hffff;
                seq_val = 16'hffff;
            end
            else
            begin
                id_val  = 16'($urandom());
                seq_val = 16'($urandom());
            end
            cfg_write(REG_EXPECTED_IDENT, id_val);
            cfg_write(REG_EXPECTED_SEQUENCE, seq_val);
            start_bytes  = bytes_sent;
            start_frames = frames_sent;
            while (bytes_sent - start_bytes < PHASE_BYTES ||
                   frames_sent - start_frames < PHASE_FRAMES)
                random_frame();
            settle();
        end

        if (mismatches == 0)
            $display("icmp_reply_matcher test passed");
        else
            $display("icmp_reply_matcher test failed");
        $finish;
    end

endmodule
